// File: src/cffa_pkg.sv
// cffa_pkg: shared sizes, codes and control types of the contiguous first-fit allocator
// depends on nothing; used by cffa_ctrl, cffa_dp and the top level
package cffa_pkg;

   localparam int BLOCKS   = 128;
   localparam int FILES    = 32;
   localparam int KEY_BITS = 16;

   localparam int BLK_AW   = $clog2(BLOCKS);
   localparam int BLK_CW   = $clog2(BLOCKS + 1);
   localparam int FILE_AW  = $clog2(FILES);
   localparam int FILE_CW  = $clog2(FILES + 1);
   localparam int CMD_W    = 2;
   localparam int LEN_W    = 8;
   localparam int STATUS_W = 3;

   localparam logic [CMD_W-1:0] CMD_CREATE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOSPACE  = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_BADLEN   = 3'd4;

   typedef struct packed {
      logic [KEY_BITS-1:0] key;
      logic [BLK_AW-1:0]   start;
      logic [BLK_CW-1:0]   size;
   } cffa_entry_type;

   localparam int ENTRY_W = $bits(cffa_entry_type);

   typedef enum logic [1:0] {
      SEL_NONE,
      SEL_NEW,
      SEL_ENTRY
   } cffa_sel_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_SCAN,
      S_MARK,
      S_APPEND,
      S_FIND,
      S_SHIFT,
      S_RESP
   } cffa_state_type;

   typedef struct packed {
      logic                load;
      logic                scan;
      logic                mark_init;
      logic                mark;
      logic                append;
      logic                find;
      logic                shift_init;
      logic                shift;
      logic                dec_count;
      logic                rsp_load;
      logic [STATUS_W-1:0] rsp_status;
      cffa_sel_type        rsp_sel;
   } cffa_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic             table_full;
      logic             len_bad;
      logic             blk_found;
      logic             scan_done;
      logic             mark_last;
      logic             hit;
      logic             tbl_done;
   } cffa_stat_type;

endpackage

// File: src/cffa_ram.sv
// cffa_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module cffa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/cffa_ctrl.sv
// cffa_ctrl: command sequencer of the allocator, owns the result valid flag
// depends on cffa_pkg; drives cffa_dp through cffa_cmd_type
module cffa_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  cffa_pkg::cffa_stat_type stat,
   output cffa_pkg::cffa_cmd_type  cmd
);

   cffa_pkg::cffa_state_type           state_ff, state_in;
   logic [cffa_pkg::STATUS_W-1:0]      res_status_ff, res_status_in;
   cffa_pkg::cffa_sel_type             res_sel_ff, res_sel_in;
   logic                               rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cffa_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_status_ff <= res_status_in;
      res_sel_ff    <= res_sel_in;
   end

   always_comb begin
      cmd           = '0;
      cmd.rsp_sel   = cffa_pkg::SEL_NONE;
      state_in      = state_ff;
      res_status_in = res_status_ff;
      res_sel_in    = res_sel_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      req_ready     = 1'b0;
      case (state_ff)
         cffa_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = cffa_pkg::S_DECODE;
            end
         end
         cffa_pkg::S_DECODE: begin
            case (stat.command)
               cffa_pkg::CMD_CREATE: begin
                  if (stat.table_full) begin
                     res_status_in = cffa_pkg::STATUS_FULL;
                     res_sel_in    = cffa_pkg::SEL_NONE;
                     state_in      = cffa_pkg::S_RESP;
                  end else if (stat.len_bad) begin
                     res_status_in = cffa_pkg::STATUS_BADLEN;
                     res_sel_in    = cffa_pkg::SEL_NONE;
                     state_in      = cffa_pkg::S_RESP;
                  end else begin
                     state_in = cffa_pkg::S_SCAN;
                  end
               end
               cffa_pkg::CMD_DELETE, cffa_pkg::CMD_LOOKUP: begin
                  state_in = cffa_pkg::S_FIND;
               end
               default: begin
                  res_status_in = cffa_pkg::STATUS_NOTFOUND;
                  res_sel_in    = cffa_pkg::SEL_NONE;
                  state_in      = cffa_pkg::S_RESP;
               end
            endcase
         end
         cffa_pkg::S_SCAN: begin
            if (stat.blk_found) begin
               cmd.mark_init = 1'b1;
               state_in      = cffa_pkg::S_MARK;
            end else if (stat.scan_done) begin
               res_status_in = cffa_pkg::STATUS_NOSPACE;
               res_sel_in    = cffa_pkg::SEL_NONE;
               state_in      = cffa_pkg::S_RESP;
            end else begin
               cmd.scan = 1'b1;
            end
         end
         cffa_pkg::S_MARK: begin
            cmd.mark = 1'b1;
            if (stat.mark_last) begin
               if (stat.command == cffa_pkg::CMD_CREATE) begin
                  state_in = cffa_pkg::S_APPEND;
               end else begin
                  cmd.shift_init = 1'b1;
                  state_in       = cffa_pkg::S_SHIFT;
               end
            end
         end
         cffa_pkg::S_APPEND: begin
            cmd.append    = 1'b1;
            res_status_in = cffa_pkg::STATUS_OK;
            res_sel_in    = cffa_pkg::SEL_NEW;
            state_in      = cffa_pkg::S_RESP;
         end
         cffa_pkg::S_FIND: begin
            if (stat.hit) begin
               if (stat.command == cffa_pkg::CMD_LOOKUP) begin
                  res_status_in = cffa_pkg::STATUS_OK;
                  res_sel_in    = cffa_pkg::SEL_ENTRY;
                  state_in      = cffa_pkg::S_RESP;
               end else begin
                  cmd.mark_init = 1'b1;
                  state_in      = cffa_pkg::S_MARK;
               end
            end else if (stat.tbl_done) begin
               res_status_in = cffa_pkg::STATUS_NOTFOUND;
               res_sel_in    = cffa_pkg::SEL_NONE;
               state_in      = cffa_pkg::S_RESP;
            end else begin
               cmd.find = 1'b1;
            end
         end
         cffa_pkg::S_SHIFT: begin
            if (stat.tbl_done) begin
               cmd.dec_count = 1'b1;
               res_status_in = cffa_pkg::STATUS_OK;
               res_sel_in    = cffa_pkg::SEL_ENTRY;
               state_in      = cffa_pkg::S_RESP;
            end else begin
               cmd.shift = 1'b1;
            end
         end
         cffa_pkg::S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = res_status_ff;
               cmd.rsp_sel    = res_sel_ff;
               rsp_valid_in   = 1'b1;
               state_in       = cffa_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = cffa_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTH
   a_resp_holds_on_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cffa_pkg::S_RESP && rsp_valid_ff && !rsp_ready)
      |=> state_ff == cffa_pkg::S_RESP)
      else $error("result overwritten while stalled");
   a_load_gives_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> rsp_valid_ff)
      else $error("result loaded without valid");
`endif

endmodule

// File: src/cffa_dp.sv
// cffa_dp: free map scan and marking, extent table search and compaction, result word
// depends on cffa_pkg and cffa_ram; controlled by cffa_ctrl
module cffa_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [cffa_pkg::CMD_W-1:0]          req_command,
   input  logic [cffa_pkg::KEY_BITS-1:0]       req_file_key,
   input  logic [cffa_pkg::LEN_W-1:0]          req_length,
   input  cffa_pkg::cffa_cmd_type              cmd,
   output cffa_pkg::cffa_stat_type             stat,
   output logic [cffa_pkg::STATUS_W-1:0]       rsp_status,
   output logic [cffa_pkg::BLK_AW-1:0]         rsp_start_block,
   output logic [cffa_pkg::BLK_CW-1:0]         rsp_block_count,
   output logic [cffa_pkg::FILE_CW-1:0]        rsp_files_in_use
);

   localparam int BAW = cffa_pkg::BLK_AW;
   localparam int BCW = cffa_pkg::BLK_CW;
   localparam int FAW = cffa_pkg::FILE_AW;
   localparam int FCW = cffa_pkg::FILE_CW;

   // latched word
   logic [cffa_pkg::CMD_W-1:0]    cmd_ff, cmd_in;
   logic [cffa_pkg::KEY_BITS-1:0] key_ff, key_in;
   logic [cffa_pkg::LEN_W-1:0]    len_ff, len_in;

   logic [FCW-1:0]                count_ff, count_in;

   // free map side
   logic [BCW-1:0]                bp_ff, bp_in;
   logic                          bpend_ff, bpend_in;
   logic [BAW-1:0]                bev_ff, bev_in;
   logic [BCW-1:0]                run_ff, run_in;
   logic                          found_ff, found_in;
   logic [BAW-1:0]                fstart_ff, fstart_in;
   logic [BCW-1:0]                left_ff, left_in;
   logic                          fill_ff, fill_in;
   logic [cffa_pkg::BLOCKS-1:0]   map_vld_ff, map_vld_in;
   logic                          mvq_ff, mvq_in;

   // table side
   logic [FCW-1:0]                tp_ff, tp_in;
   logic                          tpend_ff, tpend_in;
   logic [FAW-1:0]                tev_ff, tev_in;
   logic                          hit_ff, hit_in;
   logic [FAW-1:0]                hidx_ff, hidx_in;
   logic [BAW-1:0]                hstart_ff, hstart_in;
   logic [BCW-1:0]                hsize_ff, hsize_in;

   logic [cffa_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [BAW-1:0]                rsp_start_ff, rsp_start_in;
   logic [BCW-1:0]                rsp_count_ff, rsp_count_in;
   logic [FCW-1:0]                rsp_files_ff, rsp_files_in;

   logic                          map_rd_en, map_wr_en;
   logic [0:0]                    map_rd_data, map_wr_data;
   logic                          tbl_rd_en, tbl_wr_en;
   logic [FAW-1:0]                tbl_wr_addr;
   logic [cffa_pkg::ENTRY_W-1:0]  tbl_rd_data, tbl_wr_data;

   logic [BCW-1:0]                len_cnt;
   logic                          map_busy;
   cffa_pkg::cffa_entry_type      entry_q;
   cffa_pkg::cffa_entry_type      entry_new;

   cffa_ram #(
      .WIDTH(1),
      .DEPTH(cffa_pkg::BLOCKS)
   ) u_map_ram (
      .clock  (clock),
      .wr_en  (map_wr_en),
      .wr_addr(bp_ff[BAW-1:0]),
      .wr_data(map_wr_data),
      .rd_en  (map_rd_en),
      .rd_addr(bp_ff[BAW-1:0]),
      .rd_data(map_rd_data)
   );

   cffa_ram #(
      .WIDTH(cffa_pkg::ENTRY_W),
      .DEPTH(cffa_pkg::FILES)
   ) u_tbl_ram (
      .clock  (clock),
      .wr_en  (tbl_wr_en),
      .wr_addr(tbl_wr_addr),
      .wr_data(tbl_wr_data),
      .rd_en  (tbl_rd_en),
      .rd_addr(tp_ff[FAW-1:0]),
      .rd_data(tbl_rd_data)
   );

   assign len_cnt   = BCW'(len_ff);
   assign map_busy  = mvq_ff & map_rd_data[0];
   assign entry_q   = cffa_pkg::cffa_entry_type'(tbl_rd_data);
   assign entry_new = '{key: key_ff, start: fstart_ff, size: len_cnt};

   always_comb begin
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      len_in        = len_ff;
      count_in      = count_ff;
      bp_in         = bp_ff;
      bpend_in      = 1'b0;
      bev_in        = bev_ff;
      run_in        = run_ff;
      found_in      = found_ff;
      fstart_in     = fstart_ff;
      left_in       = left_ff;
      fill_in       = fill_ff;
      map_vld_in    = map_vld_ff;
      mvq_in        = mvq_ff;
      tp_in         = tp_ff;
      tpend_in      = 1'b0;
      tev_in        = tev_ff;
      hit_in        = hit_ff;
      hidx_in       = hidx_ff;
      hstart_in     = hstart_ff;
      hsize_in      = hsize_ff;
      rsp_status_in = rsp_status_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_files_in  = rsp_files_ff;
      map_rd_en     = 1'b0;
      map_wr_en     = 1'b0;
      map_wr_data   = fill_ff;
      tbl_rd_en     = 1'b0;
      tbl_wr_en     = 1'b0;
      tbl_wr_addr   = count_ff[FAW-1:0];
      tbl_wr_data   = entry_new;

      if (cmd.load) begin
         cmd_in   = req_command;
         key_in   = req_file_key;
         len_in   = req_length;
         bp_in    = '0;
         tp_in    = '0;
         run_in   = '0;
         found_in = 1'b0;
         hit_in   = 1'b0;
      end

      // first-fit scan: one block read issued and one evaluated per cycle
      if (cmd.scan) begin
         if (bp_ff < BCW'(cffa_pkg::BLOCKS)) begin
            map_rd_en = 1'b1;
            bpend_in  = 1'b1;
            bev_in    = bp_ff[BAW-1:0];
            mvq_in    = map_vld_ff[bp_ff[BAW-1:0]];
            bp_in     = bp_ff + BCW'(1);
         end
         if (bpend_ff && !found_ff) begin
            if (map_busy) begin
               run_in = '0;
            end else begin
               run_in = run_ff + BCW'(1);
               if (run_ff + BCW'(1) == len_cnt) begin
                  found_in  = 1'b1;
                  fstart_in = BAW'(BCW'(bev_ff) + BCW'(1) - len_cnt);
               end
            end
         end
      end

      if (cmd.mark_init) begin
         if (cmd_ff == cffa_pkg::CMD_CREATE) begin
            bp_in   = BCW'(fstart_ff);
            left_in = len_cnt;
            fill_in = 1'b1;
         end else begin
            bp_in   = BCW'(hstart_ff);
            left_in = hsize_ff;
            fill_in = 1'b0;
         end
      end

      if (cmd.mark) begin
         map_wr_en                  = 1'b1;
         map_vld_in[bp_ff[BAW-1:0]] = 1'b1;
         bp_in                      = bp_ff + BCW'(1);
         left_in                    = left_ff - BCW'(1);
      end

      // table walk, shared by search and compaction
      if (cmd.find || cmd.shift) begin
         if (tp_ff < count_ff) begin
            tbl_rd_en = 1'b1;
            tpend_in  = 1'b1;
            tev_in    = tp_ff[FAW-1:0];
            tp_in     = tp_ff + FCW'(1);
         end
      end

      if (cmd.find && tpend_ff && !hit_ff && entry_q.key == key_ff) begin
         hit_in    = 1'b1;
         hidx_in   = tev_ff;
         hstart_in = entry_q.start;
         hsize_in  = entry_q.size;
      end

      if (cmd.shift_init) begin
         tp_in = FCW'(hidx_ff) + FCW'(1);
      end

      if (cmd.shift && tpend_ff) begin
         tbl_wr_en   = 1'b1;
         tbl_wr_addr = tev_ff - FAW'(1);
         tbl_wr_data = tbl_rd_data;
      end

      if (cmd.append) begin
         tbl_wr_en = 1'b1;
         count_in  = count_ff + FCW'(1);
      end

      if (cmd.dec_count) begin
         count_in = count_ff - FCW'(1);
      end

      if (cmd.rsp_load) begin
         rsp_status_in = cmd.rsp_status;
         rsp_files_in  = count_ff;
         case (cmd.rsp_sel)
            cffa_pkg::SEL_NEW: begin
               rsp_start_in = fstart_ff;
               rsp_count_in = len_cnt;
            end
            cffa_pkg::SEL_ENTRY: begin
               rsp_start_in = hstart_ff;
               rsp_count_in = hsize_ff;
            end
            default: begin
               rsp_start_in = '0;
               rsp_count_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         map_vld_ff <= '0;
         bpend_ff   <= 1'b0;
         tpend_ff   <= 1'b0;
         found_ff   <= 1'b0;
         hit_ff     <= 1'b0;
      end else begin
         count_ff   <= count_in;
         map_vld_ff <= map_vld_in;
         bpend_ff   <= bpend_in;
         tpend_ff   <= tpend_in;
         found_ff   <= found_in;
         hit_ff     <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      len_ff        <= len_in;
      bp_ff         <= bp_in;
      bev_ff        <= bev_in;
      run_ff        <= run_in;
      fstart_ff     <= fstart_in;
      left_ff       <= left_in;
      fill_ff       <= fill_in;
      mvq_ff        <= mvq_in;
      tp_ff         <= tp_in;
      tev_ff        <= tev_in;
      hidx_ff       <= hidx_in;
      hstart_ff     <= hstart_in;
      hsize_ff      <= hsize_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_files_ff  <= rsp_files_in;
   end

   always_comb begin
      stat.command    = cmd_ff;
      stat.table_full = count_ff >= FCW'(cffa_pkg::FILES);
      stat.len_bad    = (len_ff == '0) || (32'(len_ff) > 32'(cffa_pkg::BLOCKS));
      stat.blk_found  = found_ff;
      stat.scan_done  = !bpend_ff && (bp_ff >= BCW'(cffa_pkg::BLOCKS));
      stat.mark_last  = (left_ff == BCW'(1)) || (bp_ff == BCW'(cffa_pkg::BLOCKS - 1));
      stat.hit        = hit_ff;
      stat.tbl_done   = !tpend_ff && (tp_ff >= count_ff);
   end

   assign rsp_status       = rsp_status_ff;
   assign rsp_start_block  = rsp_start_ff;
   assign rsp_block_count  = rsp_count_ff;
   assign rsp_files_in_use = rsp_files_ff;

`ifndef SYNTH
   a_append_has_room: assert property (@(posedge clock) disable iff (reset)
      cmd.append |-> count_ff < FCW'(cffa_pkg::FILES))
      else $error("append into a full table");
   a_mark_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.mark |-> bp_ff < BCW'(cffa_pkg::BLOCKS))
      else $error("free map write past the last block");
   a_dec_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.dec_count |-> count_ff != '0)
      else $error("delete from an empty table");
`endif

endmodule

// File: src/contiguous_first_fit_allocator_top.sv
// contiguous_first_fit_allocator_top: top level of the contiguous first-fit extent allocator
// depends on cffa_pkg, cffa_ctrl, cffa_dp (which holds the cffa_ram instances)
//
// usage: one request word (command, file key, length) on req_, one result word on rsp_
// every request gives exactly one result; requests are handled one at a time
// create scans the free map one block a cycle from block 0 until the first free window
// of the requested length, then marks it one block a cycle and appends the extent
// delete walks the extent table one entry a cycle, frees the extent one block a cycle
// and moves the later entries down one a cycle
// lookup walks the table only; error results (table full, bad length, unknown command)
// go straight from decoding to the result, with no walk
// the result word sits in an output register; req_ready returns once it is loaded,
// so the next request is taken while the result still waits for rsp_ready
// a stalled receiver holds the finished result, the following request then waits in
// its last step until the output register frees up
// reset (synchronous) marks every block free and empties the table, no clearing pass
module contiguous_first_fit_allocator_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [cffa_pkg::CMD_W-1:0]      req_command,
   input  logic [cffa_pkg::KEY_BITS-1:0]   req_file_key,
   input  logic [cffa_pkg::LEN_W-1:0]      req_length,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [cffa_pkg::STATUS_W-1:0]   rsp_status,
   output logic [cffa_pkg::BLK_AW-1:0]     rsp_start_block,
   output logic [cffa_pkg::BLK_CW-1:0]     rsp_block_count,
   output logic [cffa_pkg::FILE_CW-1:0]    rsp_files_in_use
);

   cffa_pkg::cffa_cmd_type  cmd;
   cffa_pkg::cffa_stat_type stat;

   cffa_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .stat     (stat),
      .cmd      (cmd)
   );

   cffa_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_command     (req_command),
      .req_file_key    (req_file_key),
      .req_length      (req_length),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_status      (rsp_status),
      .rsp_start_block (rsp_start_block),
      .rsp_block_count (rsp_block_count),
      .rsp_files_in_use(rsp_files_in_use)
   );

endmodule

// File: verif/cffa_checker.sv
// cffa_checker: watches the request and result channels of the first-fit allocator,
// predicts every result word from the accepted request words and compares field by field
// depends on cffa_pkg only
module cffa_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [cffa_pkg::CMD_W-1:0]      req_command,
   input  logic [cffa_pkg::KEY_BITS-1:0]   req_file_key,
   input  logic [cffa_pkg::LEN_W-1:0]      req_length,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [cffa_pkg::STATUS_W-1:0]   rsp_status,
   input  logic [cffa_pkg::BLK_AW-1:0]     rsp_start_block,
   input  logic [cffa_pkg::BLK_CW-1:0]     rsp_block_count,
   input  logic [cffa_pkg::FILE_CW-1:0]    rsp_files_in_use,
   output int                              fail_count,
   output int                              outstanding,
   output int                              compared,
   output int                              full_seen,
   output int                              nospace_seen
);

   typedef struct packed {
      logic [cffa_pkg::STATUS_W-1:0] status;
      logic [cffa_pkg::BLK_AW-1:0]   start;
      logic [cffa_pkg::BLK_CW-1:0]   count;
      logic [cffa_pkg::FILE_CW-1:0]  files;
   } extent_reply_type;

   logic [cffa_pkg::BLOCKS-1:0]   block_taken;
   logic [cffa_pkg::KEY_BITS-1:0] extent_key   [cffa_pkg::FILES];
   logic [cffa_pkg::BLK_AW-1:0]   extent_start [cffa_pkg::FILES];
   logic [cffa_pkg::BLK_CW-1:0]   extent_size  [cffa_pkg::FILES];
   int                            extent_count = 0;
   extent_reply_type              reply_q [$];
   int                            errs = 0;
   int                            n_compared = 0;
   int                            n_full = 0;
   int                            n_nospace = 0;

   task automatic allocate_extent(input logic [cffa_pkg::CMD_W-1:0] cmd,
                                  input logic [cffa_pkg::KEY_BITS-1:0] key,
                                  input logic [cffa_pkg::LEN_W-1:0] len,
                                  output extent_reply_type r);
      int  hit;
      int  pos;
      int  s;
      int  b;
      int  n;
      bit  fits;
      r        = '0;
      r.status = cffa_pkg::STATUS_NOTFOUND;
      hit      = -1;
      n        = int'(len);
      for (int i = 0; i < extent_count; i++)
         if (hit < 0 && extent_key[i] == key) hit = i;
      case (cmd)
         cffa_pkg::CMD_CREATE: begin
            if (extent_count >= cffa_pkg::FILES) begin
               r.status = cffa_pkg::STATUS_FULL;
            end else if (n == 0 || n > cffa_pkg::BLOCKS) begin
               r.status = cffa_pkg::STATUS_BADLEN;
            end else begin
               pos = -1;
               for (s = 0; s + n <= cffa_pkg::BLOCKS && pos < 0; s++) begin
                  fits = 1'b1;
                  for (b = s; b < s + n; b++)
                     if (block_taken[b]) fits = 1'b0;
                  if (fits) pos = s;
               end
               if (pos < 0) begin
                  r.status = cffa_pkg::STATUS_NOSPACE;
               end else begin
                  for (b = pos; b < pos + n; b++) block_taken[b] = 1'b1;
                  extent_key[extent_count]   = key;
                  extent_start[extent_count] = pos[cffa_pkg::BLK_AW-1:0];
                  extent_size[extent_count]  = len;
                  extent_count++;
                  r.status = cffa_pkg::STATUS_OK;
                  r.start  = pos[cffa_pkg::BLK_AW-1:0];
                  r.count  = len;
               end
            end
         end
         cffa_pkg::CMD_DELETE: begin
            if (hit >= 0) begin
               r.status = cffa_pkg::STATUS_OK;
               r.start  = extent_start[hit];
               r.count  = extent_size[hit];
               for (b = extent_start[hit];
                    b < extent_start[hit] + extent_size[hit] && b < cffa_pkg::BLOCKS; b++)
                  block_taken[b] = 1'b0;
               for (int i = hit; i + 1 < extent_count; i++) begin
                  extent_key[i]   = extent_key[i + 1];
                  extent_start[i] = extent_start[i + 1];
                  extent_size[i]  = extent_size[i + 1];
               end
               extent_count--;
            end
         end
         cffa_pkg::CMD_LOOKUP: begin
            if (hit >= 0) begin
               r.status = cffa_pkg::STATUS_OK;
               r.start  = extent_start[hit];
               r.count  = extent_size[hit];
            end
         end
         default: ;
      endcase
      r.files = extent_count[cffa_pkg::FILE_CW-1:0];
   endtask

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $error("%s expected %0d got %0d", name, want, got);
         errs++;
      end
   endtask

   always @(posedge clock) begin : watch
      extent_reply_type want;
      extent_reply_type got;
      if (reset) begin
         block_taken  = '0;
         extent_count = 0;
         reply_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_status, rsp_start_block, rsp_block_count, rsp_files_in_use};
            if (reply_q.size() == 0) begin
               $error("result word with no request waiting");
               errs++;
            end else begin
               want = reply_q.pop_front();
               n_compared++;
               if (want.status == cffa_pkg::STATUS_FULL) n_full++;
               if (want.status == cffa_pkg::STATUS_NOSPACE) n_nospace++;
               check_field("status", 8'(want.status), 8'(got.status));
               check_field("start_block", 8'(want.start), 8'(got.start));
               check_field("block_count", want.count, got.count);
               check_field("files_in_use", 8'(want.files), 8'(got.files));
            end
         end
         if (req_valid && req_ready) begin
            allocate_extent(req_command, req_file_key, req_length, want);
            reply_q.push_back(want);
         end
      end
      fail_count   <= errs;
      outstanding  <= reply_q.size();
      compared     <= n_compared;
      full_seen    <= n_full;
      nospace_seen <= n_nospace;
   end

endmodule

// File: verif/tb.sv
// tb: drives directed and random create, delete and lookup words into the allocator
// with bursty requests and a stalling receiver; depends on cffa_pkg, cffa_checker, the rtl
module tb;

   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int ITEM_COUNT  = 1800;
   localparam int HOLD_CYCLES = 600;
   localparam int KEY_POOL    = 40;
   localparam int DRAIN_WAIT  = 300;
   localparam logic [cffa_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

   localparam int PHASE_FILL  = 0;
   localparam int PHASE_DRAIN = 1;
   localparam int PHASE_MIXED = 2;

   typedef logic [cffa_pkg::KEY_BITS-1:0] tb_key_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [cffa_pkg::CMD_W-1:0]      req_command = cffa_pkg::CMD_CREATE;
   logic [cffa_pkg::KEY_BITS-1:0]   req_file_key = '0;
   logic [cffa_pkg::LEN_W-1:0]      req_length = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [cffa_pkg::STATUS_W-1:0]   rsp_status;
   logic [cffa_pkg::BLK_AW-1:0]     rsp_start_block;
   logic [cffa_pkg::BLK_CW-1:0]     rsp_block_count;
   logic [cffa_pkg::FILE_CW-1:0]    rsp_files_in_use;

   int fail_count;
   int outstanding;
   int compared;
   int full_seen;
   int nospace_seen;

   tb_key_type key_pool [KEY_POOL];
   bit hold_request = 1'b0;
   bit hold_done = 1'b0;
   int sent = 0;
   int burst_left = 0;

   always #5 clock = ~clock;

   contiguous_first_fit_allocator_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_file_key     (req_file_key),
      .req_length       (req_length),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_start_block  (rsp_start_block),
      .rsp_block_count  (rsp_block_count),
      .rsp_files_in_use (rsp_files_in_use)
   );

   cffa_checker reply_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_file_key     (req_file_key),
      .req_length       (req_length),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_start_block  (rsp_start_block),
      .rsp_block_count  (rsp_block_count),
      .rsp_files_in_use (rsp_files_in_use),
      .fail_count       (fail_count),
      .outstanding      (outstanding),
      .compared         (compared),
      .full_seen        (full_seen),
      .nospace_seen     (nospace_seen)
   );

   // offer one request word and return at the edge that accepts it
   task automatic send_word(input logic [cffa_pkg::CMD_W-1:0] cmd, input tb_key_type key,
                            input logic [cffa_pkg::LEN_W-1:0] len);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid    <= 1'b1;
      req_command  <= cmd;
      req_file_key <= key;
      req_length   <= len;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
   endtask

   function automatic tb_key_type pick_key();
      tb_key_type k;
      if ($urandom_range(0, 9) == 0) k = tb_key_type'($urandom);
      else k = key_pool[$urandom_range(0, KEY_POOL - 1)];
      return k;
   endfunction

   function automatic logic [cffa_pkg::LEN_W-1:0] pick_length(input int scale);
      int r;
      int n;
      r = $urandom_range(0, 99);
      if (r < 3) n = 0;
      else if (r < 6) n = $urandom_range(cffa_pkg::BLOCKS + 1, 255);
      else if (r < 8) n = cffa_pkg::BLOCKS;
      else if (r < 12) n = $urandom_range(20, cffa_pkg::BLOCKS - 1);
      else n = $urandom_range(1, scale);
      return n[cffa_pkg::LEN_W-1:0];
   endfunction

   task automatic send_random(input int phase, input int scale);
      int r;
      int c_create;
      int c_delete;
      logic [cffa_pkg::CMD_W-1:0] cmd;
      case (phase)
         PHASE_FILL: begin
            c_create = 70;
            c_delete = 80;
         end
         PHASE_DRAIN: begin
            c_create = 15;
            c_delete = 75;
         end
         default: begin
            c_create = 40;
            c_delete = 70;
         end
      endcase
      r = $urandom_range(0, 99);
      if (r < c_create) cmd = cffa_pkg::CMD_CREATE;
      else if (r < c_delete) cmd = cffa_pkg::CMD_DELETE;
      else if (r < 95) cmd = cffa_pkg::CMD_LOOKUP;
      else cmd = CMD_UNUSED;
      send_word(cmd, pick_key(),
                (cmd == cffa_pkg::CMD_CREATE) ? pick_length(scale) : 8'($urandom));
   endtask

   // receiver: one long hold-off on request, otherwise random stall patterns
   initial begin : result_side
      int run;
      int mode;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request && !hold_done) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end
         mode = $urandom_range(0, 3);
         run  = (mode == 3) ? $urandom_range(5, 40) : $urandom_range(10, 200);
         repeat (run) begin
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 1) == 1);
               2: rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= 1'b0;
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles, %0d results still expected", cycles, outstanding);
      $display("DONE: errors detected");
      $finish;
   end

   initial begin : request_side
      int phase;
      int phase_left;
      int scale;
      for (int i = 0; i < KEY_POOL; i++) key_pool[i] = tb_key_type'($urandom);
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, length limits, full-disk extent, duplicates, gap reuse
      send_word(cffa_pkg::CMD_LOOKUP, 16'h0000, 8'd0);
      send_word(cffa_pkg::CMD_DELETE, 16'h5A5A, 8'd0);
      send_word(cffa_pkg::CMD_CREATE, 16'h0001, 8'd0);
      send_word(cffa_pkg::CMD_CREATE, 16'h0001, 8'd129);
      send_word(cffa_pkg::CMD_CREATE, 16'h0001, 8'd255);
      send_word(cffa_pkg::CMD_CREATE, 16'hFFFF, 8'd128);
      send_word(cffa_pkg::CMD_CREATE, 16'h0001, 8'd1);
      send_word(cffa_pkg::CMD_LOOKUP, 16'hFFFF, 8'd0);
      send_word(cffa_pkg::CMD_DELETE, 16'hFFFF, 8'd0);
      send_word(cffa_pkg::CMD_CREATE, 16'h1234, 8'd1);
      send_word(cffa_pkg::CMD_CREATE, 16'h1234, 8'd5);
      send_word(cffa_pkg::CMD_CREATE, 16'hABCD, 8'd3);
      send_word(cffa_pkg::CMD_LOOKUP, 16'h1234, 8'd0);
      send_word(cffa_pkg::CMD_DELETE, 16'h1234, 8'd0);
      send_word(cffa_pkg::CMD_LOOKUP, 16'h1234, 8'd0);
      send_word(cffa_pkg::CMD_CREATE, 16'h0002, 8'd1);
      send_word(CMD_UNUSED, 16'hFFFF, 8'd255);
      send_word(cffa_pkg::CMD_CREATE, 16'h0003, 8'd127);
      send_word(cffa_pkg::CMD_LOOKUP, 16'hABCD, 8'd0);
      send_word(cffa_pkg::CMD_DELETE, 16'hABCD, 8'd0);
      send_word(cffa_pkg::CMD_DELETE, 16'h0002, 8'd0);
      send_word(cffa_pkg::CMD_DELETE, 16'h1234, 8'd0);

      // receiver holds off while the first random words keep coming
      hold_request <= 1'b1;
      phase      = PHASE_FILL;
      phase_left = 0;
      scale      = 3;
      for (int i = 0; i < ITEM_COUNT; i++) begin
         if (phase_left == 0) begin
            phase      = $urandom_range(PHASE_FILL, PHASE_MIXED);
            phase_left = $urandom_range(60, 150);
            scale      = $urandom_range(2, 16);
         end
         phase_left--;
         send_random(phase, scale);
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("%0d request words sent, %0d result words compared", sent, compared);
      $display("%0d table-full and %0d no-space answers seen", full_seen, nospace_seen);
      if (fail_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
